>>> sv/urc_pkg.sv
// Shared types and constants of the ultrasonic ranging controller.
`default_nettype none

package urc_pkg;

    // Fixed field widths
    localparam int unsigned US20_W  = 20;
    localparam int unsigned AGE_W   = 32;
    localparam int unsigned PULSE_W = 4;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // Sequencer phases
    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_SETTLE  = 3'd1,
        PH_TLOW    = 3'd2,
        PH_THIGH   = 3'd3,
        PH_CLEAR   = 3'd4,
        PH_RISE    = 3'd5,
        PH_MEASURE = 3'd6
    } t_phase;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALWAYS_ON   = 3'd0,
        CFG_AUTO_CUT    = 3'd1,
        CFG_SETTLE      = 3'd2,
        CFG_ECHO_TMO    = 3'd3,
        CFG_POWER_CUT   = 3'd4
    } t_cfg_idx;

    // Configuration register set
    typedef struct packed {
        logic               always_on;
        logic               auto_cut_enable;
        logic [US20_W-1:0]  settle_us;
        logic [US20_W-1:0]  echo_timeout_us;
        logic [AGE_W-1:0]   power_cut_us;
    } t_cfg;

    // One result word
    typedef struct packed {
        logic               power_enable;
        logic               trigger;
        logic               busy_res;
        logic               result_valid;
        logic               echo_found;
        logic [US20_W-1:0]  echo_width_us;
    } t_result;

    localparam logic [US20_W-1:0] ECHO_TMO_RST  = 20'd30000;
    localparam logic [AGE_W-1:0]  POWER_CUT_RST = 32'hFFFF_FFFF;

endpackage

`default_nettype wire

>>> sv/urc_tick_if.sv
// Input channel: one tick word with echo sample and measure request.
`default_nettype none

interface urc_tick_if;
    logic valid;
    logic ready;
    logic echo_level;
    logic measure_request;

    modport source (output valid, output echo_level, output measure_request, input ready);
    modport sink   (input valid, input echo_level, input measure_request, output ready);
endinterface

`default_nettype wire

>>> sv/urc_result_if.sv
// Output channel: one result word per tick.
`default_nettype none

interface urc_result_if;
    logic        valid;
    logic        ready;
    logic        power_enable;
    logic        trigger;
    logic        busy_res;
    logic        result_valid;
    logic        echo_found;
    logic [19:0] echo_width_us;

    modport source (output valid, output power_enable, output trigger, output busy_res,
                    output result_valid, output echo_found, output echo_width_us,
                    input ready);
    modport sink   (input valid, input power_enable, input trigger, input busy_res,
                    input result_valid, input echo_found, input echo_width_us,
                    output ready);
endinterface

`default_nettype wire

>>> sv/urc_cfg.sv
// Configuration register file of the ranging controller.
`default_nettype none

module urc_cfg
    import urc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    // Write the addressed register; unknown indexes drop the word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.always_on       <= 1'b0;
            r_cfg.auto_cut_enable <= 1'b0;
            r_cfg.settle_us       <= '0;
            r_cfg.echo_timeout_us <= ECHO_TMO_RST;
            r_cfg.power_cut_us    <= POWER_CUT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ALWAYS_ON: r_cfg.always_on       <= i_cfg_wdata[0];
                CFG_AUTO_CUT:  r_cfg.auto_cut_enable <= i_cfg_wdata[0];
                CFG_SETTLE:    r_cfg.settle_us       <= i_cfg_wdata[US20_W-1:0];
                CFG_ECHO_TMO:  r_cfg.echo_timeout_us <= i_cfg_wdata[US20_W-1:0];
                CFG_POWER_CUT: r_cfg.power_cut_us    <= i_cfg_wdata[AGE_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> sv/urc_seq.sv
// Ranging sequencer: power, trigger pulse, edge waits and echo width count.
`default_nettype none

module urc_seq
    import urc_pkg::*;
#(
    parameter int unsigned TRIG_LOW_US  = 2,
    parameter int unsigned TRIG_HIGH_US = 10
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_acc,
    input  wire logic i_echo,
    input  wire logic i_req,
    input  wire t_cfg i_cfg,
    output t_result   o_res
);

    localparam logic [PULSE_W-1:0] LOW_TICKS  = PULSE_W'(TRIG_LOW_US);
    localparam logic [PULSE_W-1:0] HIGH_TICKS = PULSE_W'(TRIG_HIGH_US);

    t_phase             r_phase, n_phase;
    logic               r_powered, n_powered;
    logic [US20_W-1:0]  r_pwr_age, n_pwr_age;
    logic [AGE_W-1:0]   r_idle_age, n_idle_age;
    logic [US20_W-1:0]  r_wait, n_wait;
    logic [US20_W-1:0]  r_high, n_high;
    logic [PULSE_W-1:0] r_pulse, n_pulse;

    logic              trig, done, found;
    logic [US20_W-1:0] width;

    // Hold state between ticks, advance on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_powered  <= 1'b0;
            r_pwr_age  <= '0;
            r_idle_age <= '0;
            r_wait     <= '0;
            r_high     <= '0;
            r_pulse    <= '0;
        end else if (i_acc) begin
            r_phase    <= n_phase;
            r_powered  <= n_powered;
            r_pwr_age  <= n_pwr_age;
            r_idle_age <= n_idle_age;
            r_wait     <= n_wait;
            r_high     <= n_high;
            r_pulse    <= n_pulse;
        end
    end

    // Next state and result of one tick
    always_comb begin
        n_phase    = r_phase;
        n_powered  = r_powered;
        n_pwr_age  = r_pwr_age;
        n_idle_age = r_idle_age;
        n_wait     = r_wait;
        n_high     = r_high;
        n_pulse    = r_pulse;
        trig       = 1'b0;
        done       = 1'b0;
        found      = 1'b0;
        width      = '0;

        unique case (r_phase)
            PH_IDLE: begin
                // Forced power or idle cut, then the request may power up again
                if (i_cfg.always_on) begin
                    if (!n_powered) begin
                        n_powered  = 1'b1;
                        n_pwr_age  = '0;
                        n_idle_age = '0;
                    end
                end else if (i_cfg.auto_cut_enable && n_powered &&
                             (n_idle_age >= i_cfg.power_cut_us)) begin
                    n_powered = 1'b0;
                end
                if (i_req) begin
                    if (!n_powered) begin
                        n_powered  = 1'b1;
                        n_pwr_age  = '0;
                        n_idle_age = '0;
                    end
                    n_phase = PH_SETTLE;
                end
            end
            PH_SETTLE: begin
                if (r_pwr_age >= i_cfg.settle_us) begin
                    n_phase = PH_TLOW;
                    n_pulse = '0;
                end
            end
            PH_TLOW: begin
                n_pulse = r_pulse + 1'b1;
                if (n_pulse >= LOW_TICKS) begin
                    n_phase = PH_THIGH;
                    n_pulse = '0;
                end
            end
            PH_THIGH: begin
                trig    = 1'b1;
                n_pulse = r_pulse + 1'b1;
                if (n_pulse >= HIGH_TICKS) begin
                    n_phase = PH_CLEAR;
                    n_wait  = '0;
                end
            end
            PH_CLEAR, PH_RISE: begin
                // A low sample in the clear wait counts at once as a rise-wait sample
                if (r_phase == PH_CLEAR && i_echo) begin
                    if (r_wait >= i_cfg.echo_timeout_us) done = 1'b1;
                    else n_wait = r_wait + 1'b1;
                end else if (!i_echo) begin
                    n_phase = PH_RISE;
                    if (r_wait >= i_cfg.echo_timeout_us) done = 1'b1;
                    else n_wait = r_wait + 1'b1;
                end else begin
                    n_phase = PH_MEASURE;
                    n_high  = US20_W'(1);
                end
            end
            PH_MEASURE: begin
                if (i_echo) begin
                    if (r_high >= i_cfg.echo_timeout_us) done = 1'b1;
                    else n_high = r_high + 1'b1;
                end else begin
                    done  = 1'b1;
                    found = 1'b1;
                    width = r_high;
                end
            end
            default: n_phase = PH_IDLE;
        endcase

        if (done) begin
            n_phase    = PH_IDLE;
            n_idle_age = '0;
        end

        // Saturating ages while powered
        if (n_powered) begin
            if (n_pwr_age != '1)  n_pwr_age  = n_pwr_age + 1'b1;
            if (n_idle_age != '1) n_idle_age = n_idle_age + 1'b1;
        end
    end

    assign o_res.power_enable  = n_powered;
    assign o_res.trigger       = trig;
    assign o_res.busy_res      = (n_phase != PH_IDLE);
    assign o_res.result_valid  = done;
    assign o_res.echo_found    = found;
    assign o_res.echo_width_us = width;

    // Power never drops during a sequence
    a_power_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_acc && r_phase != PH_IDLE && r_powered) |=> r_powered)
        else $error("sensor power dropped during a measurement");

    // A request on an idle tick starts the settle wait
    a_req_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_acc && r_phase == PH_IDLE && i_req) |=> (r_phase == PH_SETTLE && r_powered))
        else $error("measure request did not start a sequence");

    // The trigger pulse is followed by the clear wait with a fresh counter
    a_trig_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_acc && r_phase == PH_THIGH && n_phase == PH_CLEAR) |=> (r_wait == '0))
        else $error("edge wait counter not cleared after trigger");

endmodule

`default_nettype wire

>>> sv/urc_skid.sv
// Output register with one skid word between sequencer and result channel.
`default_nettype none

module urc_skid
    import urc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_data,
    output logic         o_space,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_data
);

    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;
    logic    pop;

    assign pop     = r_out_valid && i_ready;
    assign o_space = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // Control: output word valid and skid word valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) r_skid_valid <= 1'b0;
        end else if (i_push) begin
            if (r_out_valid && !pop) r_skid_valid <= 1'b1;
            r_out_valid <= 1'b1;
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload: refill the output from the skid first, else from the sequencer
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) r_out <= r_skid;
        end else if (i_push) begin
            if (!r_out_valid || pop) r_out  <= i_data;
            else                     r_skid <= i_data;
        end
    end

    // The skid word only exists behind a waiting output word
    a_skid_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word held with empty output register");

    // A stalled output word is kept
    a_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> r_out_valid)
        else $error("result word lost under stall");

endmodule

`default_nettype wire

>>> sv/ultrasonic_ranging_controller_top.sv
// Top level of the ultrasonic ranging controller.
//
//  channel     dir  handshake            word contents
//  i_tick_ch   in   valid / ready        echo_level, measure_request
//  o_res_ch    out  valid / ready        power_enable, trigger, busy_res,
//                                        result_valid, echo_found, echo_width_us
//  cfg port    in   i_cfg_we (no wait)   i_cfg_idx, i_cfg_wdata
//
// One tick word is taken every clock cycle while no skid word is held; its result
// word is registered. The sequencer state updates in a single pass per word.
// A stalled result channel fills the output register and then the skid word;
// input ready drops only while the skid word is held.
// Synchronous active-low reset: power off, phase idle, registers at reset values.
`default_nettype none

module ultrasonic_ranging_controller_top
    import urc_pkg::*;
#(
    parameter int unsigned TRIG_LOW_US  = 2,
    parameter int unsigned TRIG_HIGH_US = 10
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    urc_tick_if.sink                   i_tick_ch,
    urc_result_if.source               o_res_ch,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cfg    cfg;
    t_result seq_res, out_res;
    logic    space, acc;

    assign i_tick_ch.ready = space;
    assign acc = i_tick_ch.valid && space;

    urc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    urc_seq #(
        .TRIG_LOW_US  (TRIG_LOW_US),
        .TRIG_HIGH_US (TRIG_HIGH_US)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .i_echo  (i_tick_ch.echo_level),
        .i_req   (i_tick_ch.measure_request),
        .i_cfg   (cfg),
        .o_res   (seq_res)
    );

    urc_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (acc),
        .i_data  (seq_res),
        .o_space (space),
        .o_valid (o_res_ch.valid),
        .i_ready (o_res_ch.ready),
        .o_data  (out_res)
    );

    // Unpack the result word onto the channel
    assign o_res_ch.power_enable  = out_res.power_enable;
    assign o_res_ch.trigger       = out_res.trigger;
    assign o_res_ch.busy_res      = out_res.busy_res;
    assign o_res_ch.result_valid  = out_res.result_valid;
    assign o_res_ch.echo_found    = out_res.echo_found;
    assign o_res_ch.echo_width_us = out_res.echo_width_us;

endmodule

`default_nettype wire
